[rtl/u8e1_pkg.sv]
// Shared types and constants for the 8E1 UART transceiver.
`timescale 1ns / 1ps
package u8e1_pkg;

  // Register reset values.
  localparam logic [15:0] BIT_PERIOD_RST  = 16'd833;
  localparam logic [14:0] HALF_PERIOD_RST = 15'd416;

  // Frame lengths in bit slots.
  localparam logic [3:0] TX_FRAME_BITS = 4'd11;
  localparam logic [3:0] RX_FRAME_BITS = 4'd10;

  // Configuration register indexes.
  typedef enum logic {
    CFG_BIT_PERIOD  = 1'b0,
    CFG_HALF_PERIOD = 1'b1
  } cfg_idx_t;

  // Receiver phase.
  typedef enum logic {
    RX_IDLE  = 1'b0,
    RX_FRAME = 1'b1
  } rx_phase_t;

  // Transmitter result fields.
  typedef struct packed {
    logic line;
    logic busy;
    logic done;
  } tx_res_t;

  // Receiver result fields.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       error;
  } rx_res_t;

  // One result item.
  typedef struct packed {
    tx_res_t tx;
    rx_res_t rx;
  } out_item_t;

endpackage

[rtl/u8e1_if.sv]
// Request and result channel interfaces for the 8E1 UART transceiver.
`timescale 1ns / 1ps
interface u8e1_in_if;
  logic       valid;
  logic       ready;
  logic       rx_line;
  logic       tx_start;
  logic [7:0] tx_byte;

  modport source(output valid, rx_line, tx_start, tx_byte, input ready);
  modport sink(input valid, rx_line, tx_start, tx_byte, output ready);
endinterface

interface u8e1_out_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       tx_busy;
  logic       tx_done;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       rx_error;

  modport source(output valid, tx_line, tx_busy, tx_done, rx_valid, rx_byte, rx_error,
                 input ready);
  modport sink(input valid, tx_line, tx_busy, tx_done, rx_valid, rx_byte, rx_error,
               output ready);
endinterface

[rtl/u8e1_tx.sv]
// Transmitter: bit timer and frame shift register, one tick per accepted request.
`timescale 1ns / 1ps
module u8e1_tx (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic              tx_start,
  input  logic [7:0]        tx_byte,
  input  logic [15:0]       bit_period,
  output u8e1_pkg::tx_res_t res
);

  logic [10:0] shift_r, shift_nxt;
  logic [3:0]  bits_left_r, bits_left_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic        active_r, active_nxt;
  logic        level_r, level_nxt;
  logic        done;

  // Next state for one tick.
  always_comb begin
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    timer_nxt     = timer_r;
    active_nxt    = active_r;
    level_nxt     = level_r;
    done          = 1'b0;
    if (active_r) begin
      if (timer_r <= 16'd1) begin
        timer_nxt = bit_period;
        if (bits_left_r != 4'd0) begin
          level_nxt     = shift_r[0];
          shift_nxt     = {1'b1, shift_r[10:1]};
          bits_left_nxt = bits_left_r - 4'd1;
        end else begin
          active_nxt = 1'b0;
          level_nxt  = 1'b1;
          done       = 1'b1;
        end
      end else begin
        timer_nxt = timer_r - 16'd1;
      end
    end else if (tx_start) begin
      // Stop, even parity, data LSB first, start.
      shift_nxt     = {1'b1, ^tx_byte, tx_byte, 1'b0};
      bits_left_nxt = u8e1_pkg::TX_FRAME_BITS;
      timer_nxt     = bit_period;
      active_nxt    = 1'b1;
      level_nxt     = 1'b1;
    end
  end

  // Result shows the state after the tick.
  always_comb begin
    res.line = level_nxt;
    res.busy = active_nxt;
    res.done = done;
  end

  // State registers advance only on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '1;
      bits_left_r <= '0;
      timer_r     <= '0;
      active_r    <= 1'b0;
      level_r     <= 1'b1;
    end else if (tick) begin
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      timer_r     <= timer_nxt;
      active_r    <= active_nxt;
      level_r     <= level_nxt;
    end
  end

endmodule

[rtl/u8e1_rx.sv]
// Receiver: start edge detect, bit-center sampling and parity/stop checks.
`timescale 1ns / 1ps
module u8e1_rx (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic              rx_line,
  input  logic [15:0]       bit_period,
  input  logic [14:0]       half_period,
  output u8e1_pkg::rx_res_t res
);

  u8e1_pkg::rx_phase_t phase_r, phase_nxt;
  logic [9:0]  shift_r, shift_nxt;
  logic [3:0]  bits_left_r, bits_left_nxt;
  logic [16:0] timer_r, timer_nxt;
  logic        ones_odd_r, ones_odd_nxt;
  logic        fault_r, fault_nxt;
  logic        prev_r;
  logic [9:0]  shifted;

  assign shifted = {rx_line, shift_r[9:1]};

  // Next state and result for one tick.
  always_comb begin
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    timer_nxt     = timer_r;
    ones_odd_nxt  = ones_odd_r;
    fault_nxt     = fault_r;
    res           = '0;
    case (phase_r)
      u8e1_pkg::RX_IDLE: begin
        if (prev_r && !rx_line) begin
          phase_nxt     = u8e1_pkg::RX_FRAME;
          timer_nxt     = {1'b0, bit_period} + {2'b00, half_period};
          bits_left_nxt = u8e1_pkg::RX_FRAME_BITS;
          shift_nxt     = '0;
          ones_odd_nxt  = 1'b0;
          fault_nxt     = 1'b0;
        end
      end
      u8e1_pkg::RX_FRAME: begin
        if (timer_r <= 17'd1) begin
          timer_nxt = {1'b0, bit_period};
          shift_nxt = shifted;
          if (bits_left_r > 4'd1) begin
            ones_odd_nxt  = ones_odd_r ^ rx_line;
            bits_left_nxt = bits_left_r - 4'd1;
          end else begin
            // Stop sample: report the frame and return to idle.
            res.valid     = 1'b1;
            res.data      = shifted[7:0];
            res.error     = fault_r | !rx_line | ones_odd_r;
            phase_nxt     = u8e1_pkg::RX_IDLE;
            bits_left_nxt = '0;
            ones_odd_nxt  = 1'b0;
            fault_nxt     = 1'b0;
          end
        end else begin
          timer_nxt = timer_r - 17'd1;
        end
      end
      default: begin
        phase_nxt = u8e1_pkg::RX_IDLE;
      end
    endcase
  end

  // State registers advance only on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= u8e1_pkg::RX_IDLE;
      shift_r     <= '0;
      bits_left_r <= '0;
      timer_r     <= '0;
      ones_odd_r  <= 1'b0;
      fault_r     <= 1'b0;
      prev_r      <= 1'b1;
    end else if (tick) begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      timer_r     <= timer_nxt;
      ones_odd_r  <= ones_odd_nxt;
      fault_r     <= fault_nxt;
      prev_r      <= rx_line;
    end
  end

endmodule

[rtl/u8e1_skid.sv]
// Result register with a skid stage, so requests keep flowing while a result waits.
`timescale 1ns / 1ps
module u8e1_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  u8e1_pkg::out_item_t push_data,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output u8e1_pkg::out_item_t out_data
);

  logic                main_valid_r, main_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  u8e1_pkg::out_item_t main_r, main_nxt;
  u8e1_pkg::out_item_t skid_r, skid_nxt;

  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // Refill the result register from the skid stage first, then from a new request.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || out_ready) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  // Control bits take reset; payload does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

[rtl/uart_8e1_transceiver.sv]
// Top level of the bit-timed 8E1 UART transceiver.
//
//   channel  | dir | contents
//   ---------+-----+-----------------------------------------------------
//   in_ch    | in  | one clock tick: rx_line, tx_start, tx_byte
//   out_ch   | out | line state after the tick: tx_line/busy/done, rx_*
//   cfg_*    | in  | register write: 0 bit_period, 1 half_period
//
// Every accepted request advances the TX and RX bit timers by one tick and
// yields one registered result; one request per cycle while the skid is empty.
// The result register plus a one-entry skid stage keep in_ch.ready high while
// a single result waits; ready drops only once two results are held.
// Reset (rst_n, synchronous) returns both sides to idle and the registers to
// 833 and 416; there is no clearing pass.
`timescale 1ns / 1ps
module uart_8e1_transceiver (
  input  logic               clk,
  input  logic               rst_n,
  u8e1_in_if.sink            in_ch,
  u8e1_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [15:0]        cfg_wdata
);

  logic [15:0]         bit_period_r;
  logic [14:0]         half_period_r;
  logic                tick;
  logic                can_push;
  u8e1_pkg::tx_res_t   tx_res;
  u8e1_pkg::rx_res_t   rx_res;
  u8e1_pkg::out_item_t item;
  u8e1_pkg::out_item_t out_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= u8e1_pkg::BIT_PERIOD_RST;
      half_period_r <= u8e1_pkg::HALF_PERIOD_RST;
    end else if (cfg_we) begin
      case (u8e1_pkg::cfg_idx_t'(cfg_idx))
        u8e1_pkg::CFG_BIT_PERIOD:  bit_period_r  <= cfg_wdata;
        u8e1_pkg::CFG_HALF_PERIOD: half_period_r <= cfg_wdata[14:0];
        default: begin
          bit_period_r <= bit_period_r;
        end
      endcase
    end
  end

  // A request is one tick.
  assign in_ch.ready = can_push;
  assign tick        = in_ch.valid & can_push;

  u8e1_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .tx_start   (in_ch.tx_start),
    .tx_byte    (in_ch.tx_byte),
    .bit_period (bit_period_r),
    .res        (tx_res)
  );

  u8e1_rx u_rx (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .rx_line     (in_ch.rx_line),
    .bit_period  (bit_period_r),
    .half_period (half_period_r),
    .res         (rx_res)
  );

  assign item.tx = tx_res;
  assign item.rx = rx_res;

  u8e1_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick),
    .push_data (item),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_item)
  );

  // Result fields.
  assign out_ch.tx_line  = out_item.tx.line;
  assign out_ch.tx_busy  = out_item.tx.busy;
  assign out_ch.tx_done  = out_item.tx.done;
  assign out_ch.rx_valid = out_item.rx.valid;
  assign out_ch.rx_byte  = out_item.rx.data;
  assign out_ch.rx_error = out_item.rx.error;

endmodule

[bench/u8e1_frame_checker.sv]
// Line-state predictor and result checker for the 8E1 UART transceiver bench.
`timescale 1ns / 1ps
module u8e1_frame_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  u8e1_in_if                   tick_ch,
  u8e1_out_if                  line_ch,
  input  logic                 cfg_we,
  input  u8e1_pkg::cfg_idx_t   cfg_idx,
  input  logic [15:0]          cfg_wdata,
  output int unsigned          fail_count,
  output int unsigned          awaited
);

  // Copy of the programmed bit timing.
  logic [15:0] bit_per;
  logic [14:0] half_per;

  // Transmitter state.
  logic [10:0] tx_sr;
  logic [3:0]  tx_left;
  logic [15:0] tx_tmr;
  logic        tx_on;
  logic        tx_lvl;

  // Receiver state.
  logic [9:0]           rx_sr;
  logic [3:0]           rx_left;
  logic [16:0]          rx_tmr;
  u8e1_pkg::rx_phase_t  rx_ph;
  logic                 rx_odd;
  logic                 rx_bad;
  logic                 rx_prev;

  // Line states predicted for accepted ticks, oldest first.
  u8e1_pkg::out_item_t line_states_q[$];

  // Print one mismatch line and count it.
  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Advance both bit timers by one tick and return the line state after it.
  function automatic u8e1_pkg::out_item_t advance_one_tick(input logic line,
                                                           input logic start,
                                                           input logic [7:0] data);
    u8e1_pkg::out_item_t r;
    r = '0;

    // Transmitter: a request is taken only when idle at the start of the tick.
    if (tx_on) begin
      if (tx_tmr <= 16'd1) begin
        tx_tmr = bit_per;
        if (tx_left != 4'd0) begin
          tx_lvl  = tx_sr[0];
          tx_sr   = {1'b1, tx_sr[10:1]};
          tx_left = tx_left - 4'd1;
        end else begin
          tx_on    = 1'b0;
          tx_lvl   = 1'b1;
          r.tx.done = 1'b1;
        end
      end else begin
        tx_tmr = tx_tmr - 16'd1;
      end
    end else if (start) begin
      tx_sr   = {1'b1, ^data, data, 1'b0};
      tx_left = u8e1_pkg::TX_FRAME_BITS;
      tx_tmr  = bit_per;
      tx_on   = 1'b1;
      tx_lvl  = 1'b1;
    end

    // Receiver: falling edges only count while waiting for a frame.
    if (rx_ph == u8e1_pkg::RX_IDLE) begin
      if (rx_prev && !line) begin
        rx_ph   = u8e1_pkg::RX_FRAME;
        rx_tmr  = {1'b0, bit_per} + {2'b00, half_per};
        rx_left = u8e1_pkg::RX_FRAME_BITS;
        rx_sr   = '0;
        rx_odd  = 1'b0;
        rx_bad  = 1'b0;
      end
    end else if (rx_tmr <= 17'd1) begin
      rx_tmr = {1'b0, bit_per};
      rx_sr  = {line, rx_sr[9:1]};
      if (rx_left > 4'd1) begin
        rx_odd = rx_odd ^ line;
      end
      if (rx_left <= 4'd1) begin
        if (!line || rx_odd) begin
          rx_bad = 1'b1;
        end
        r.rx.valid = 1'b1;
        r.rx.data  = rx_sr[7:0];
        r.rx.error = rx_bad;
        rx_ph   = u8e1_pkg::RX_IDLE;
        rx_left = 4'd0;
        rx_odd  = 1'b0;
        rx_bad  = 1'b0;
      end else begin
        rx_left = rx_left - 4'd1;
      end
    end else begin
      rx_tmr = rx_tmr - 17'd1;
    end
    rx_prev = line;

    r.tx.line = tx_lvl;
    r.tx.busy = tx_on;
    return r;
  endfunction

  // Track register writes, predict each accepted tick, compare each result.
  always @(posedge clk) begin
    u8e1_pkg::out_item_t want;
    if (!rst_n) begin
      bit_per  = u8e1_pkg::BIT_PERIOD_RST;
      half_per = u8e1_pkg::HALF_PERIOD_RST;
      tx_sr    = '1;
      tx_left  = '0;
      tx_tmr   = '0;
      tx_on    = 1'b0;
      tx_lvl   = 1'b1;
      rx_sr    = '0;
      rx_left  = '0;
      rx_tmr   = '0;
      rx_ph    = u8e1_pkg::RX_IDLE;
      rx_odd   = 1'b0;
      rx_bad   = 1'b0;
      rx_prev  = 1'b1;
      line_states_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          u8e1_pkg::CFG_BIT_PERIOD:  bit_per = cfg_wdata;
          u8e1_pkg::CFG_HALF_PERIOD: half_per = cfg_wdata[14:0];
          default: begin
          end
        endcase
      end
      if (tick_ch.valid && tick_ch.ready) begin
        line_states_q.push_back(advance_one_tick(tick_ch.rx_line, tick_ch.tx_start,
                                                 tick_ch.tx_byte));
      end
      if (line_ch.valid && line_ch.ready) begin
        if (line_states_q.size() == 0) begin
          flag_mismatch("line state arrived with no tick awaiting it");
        end else begin
          want = line_states_q.pop_front();
          check_field("tx_line", 8'(line_ch.tx_line), 8'(want.tx.line));
          check_field("tx_busy", 8'(line_ch.tx_busy), 8'(want.tx.busy));
          check_field("tx_done", 8'(line_ch.tx_done), 8'(want.tx.done));
          check_field("rx_valid", 8'(line_ch.rx_valid), 8'(want.rx.valid));
          check_field("rx_byte", line_ch.rx_byte, want.rx.data);
          check_field("rx_error", 8'(line_ch.rx_error), 8'(want.rx.error));
        end
      end
    end
    awaited <= line_states_q.size();
  end

endmodule

[bench/tb_uart_8e1_transceiver.sv]
// Top of the 8E1 UART transceiver bench: clock, reset, tick stimulus and verdict.
`timescale 1ns / 1ps
module tb_uart_8e1_transceiver;

  localparam int unsigned CYCLE_LIMIT  = 20_000;
  localparam int unsigned PHASE_TICKS  = 64;
  localparam int unsigned LONG_TICKS   = 40;
  localparam int unsigned PHASE_BIT [8] = '{4, 5, 6, 8, 4, 7, 10, 5};
  localparam int unsigned PHASE_HALF[8] = '{2, 2, 3, 4, 3, 3, 5, 4};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  u8e1_pkg::cfg_idx_t cfg_idx;
  logic [15:0]        cfg_wdata;
  int unsigned        fail_count;
  int unsigned        awaited;
  int unsigned        cycles = 0;

  // Stimulus knobs.
  logic        calm;        // no random gaps or stalls while set
  int unsigned tx_pct;      // chance in percent of a transmit request per tick
  int unsigned bit_len;     // bit period currently programmed
  int unsigned ticks_sent;

  u8e1_in_if  tick_ch ();
  u8e1_out_if line_ch ();

  uart_8e1_transceiver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (tick_ch),
    .out_ch    (line_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  u8e1_frame_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_ch    (tick_ch),
    .line_ch    (line_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  always #5 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side stalls at random unless calm.
  always @(posedge clk) begin
    line_ch.ready <= calm || ($urandom_range(99) >= 15);
  end

  // Send one tick request, with random gaps before it.
  task automatic send_tick(input logic line, input logic start, input logic [7:0] data);
    while (!calm && $urandom_range(99) < 15) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid    <= 1'b1;
    tick_ch.rx_line  <= line;
    tick_ch.tx_start <= start;
    tick_ch.tx_byte  <= data;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Hold the receive line for a number of ticks, with random transmit requests.
  task automatic line_ticks(input logic line, input int unsigned count);
    repeat (count) send_tick(line, $urandom_range(99) < tx_pct, 8'($urandom));
  endtask

  // Drive the first slots of a receive frame, each one bit period long.
  task automatic drive_rx_frame(input logic [7:0] data, input logic par_flip,
                                input logic stop_lvl, input int unsigned slots);
    logic [10:0] frame;
    frame = {stop_lvl, (^data) ^ par_flip, data, 1'b0};
    for (int s = 0; s < slots; s++) begin
      line_ticks(frame[s], bit_len);
    end
  endtask

  // Idle line long enough for both directions to finish their frames.
  task automatic settle();
    tx_pct = 0;
    line_ticks(1'b1, 13 * bit_len);
  endtask

  // Program both periods once every result is in.
  task automatic set_periods(input logic [15:0] bp, input logic [14:0] hp);
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= u8e1_pkg::CFG_BIT_PERIOD;
    cfg_wdata <= bp;
    @(posedge clk);
    cfg_idx   <= u8e1_pkg::CFG_HALF_PERIOD;
    cfg_wdata <= {1'b0, hp};
    @(posedge clk);
    cfg_we    <= 1'b0;
    bit_len = bp;
  endtask

  // Mostly well-formed frames with random content, plus noise and cut frames.
  task automatic random_phase(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      pick   = $urandom_range(99);
      tx_pct = $urandom_range(20);
      if (pick < 70) begin
        drive_rx_frame(8'($urandom), $urandom_range(99) < 15, $urandom_range(99) >= 10, 11);
        line_ticks(1'b1, $urandom_range(2 * bit_len));
      end else if (pick < 85) begin
        repeat ($urandom_range(30, 5)) begin
          send_tick(1'($urandom_range(1)), $urandom_range(99) < tx_pct, 8'($urandom));
        end
      end else if (pick < 95) begin
        drive_rx_frame(8'($urandom), 1'b0, 1'b1, $urandom_range(10, 1));
        line_ticks(1'b1, $urandom_range(2 * bit_len, 1));
      end else begin
        line_ticks(1'b1, $urandom_range(20, 1));
      end
    end
    settle();
  endtask

  initial begin
    rst_n            = 1'b0;
    tick_ch.valid    = 1'b0;
    tick_ch.rx_line  = 1'b1;
    tick_ch.tx_start = 1'b0;
    tick_ch.tx_byte  = 8'h00;
    line_ch.ready    = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = u8e1_pkg::CFG_BIT_PERIOD;
    cfg_wdata        = 16'h0000;
    calm             = 1'b0;
    tx_pct           = 0;
    bit_len          = u8e1_pkg::BIT_PERIOD_RST;
    ticks_sent       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // A few idle ticks at the reset timing.
    line_ticks(1'b1, 20);

    // Directed frames at the shortest timing.
    set_periods(16'd4, 15'd2);
    send_tick(1'b1, 1'b1, 8'h00);
    drive_rx_frame(8'h00, 1'b0, 1'b1, 11);
    line_ticks(1'b1, 2 * bit_len);
    send_tick(1'b1, 1'b1, 8'hFF);
    drive_rx_frame(8'hFF, 1'b0, 1'b1, 11);
    line_ticks(1'b1, 2 * bit_len);
    // Bad parity while a transmit request is held on every tick.
    tx_pct = 100;
    drive_rx_frame(8'h5A, 1'b1, 1'b1, 11);
    line_ticks(1'b1, 4 * bit_len);
    tx_pct = 0;
    // Missing stop bit, then the line stays low before going idle.
    drive_rx_frame(8'h81, 1'b0, 1'b0, 11);
    line_ticks(1'b0, 3 * bit_len);
    line_ticks(1'b1, 2);
    // Falling edges inside the data bits, then a frame cut short.
    drive_rx_frame(8'h55, 1'b0, 1'b1, 11);
    drive_rx_frame(8'h7E, 1'b0, 1'b1, 4);
    settle();

    // Random traffic over several timings, one phase without gaps or stalls.
    for (int p = 0; p < 8; p++) begin
      set_periods(16'(PHASE_BIT[p]), 15'(PHASE_HALF[p]));
      calm = (p == 2);
      random_phase(PHASE_TICKS);
    end
    calm = 1'b0;

    // Largest periods loaded, then changed to the smallest mid-frame; the
    // loaded timers keep counting down, and only later reloads use new values.
    set_periods(16'hFFFF, 15'h7FFF);
    send_tick(1'b0, 1'b1, 8'hC3);
    line_ticks(1'b0, 5);
    set_periods(16'd4, 15'd2);
    tx_pct = 5;
    repeat (LONG_TICKS) begin
      send_tick(1'($urandom_range(1)), $urandom_range(99) < tx_pct, 8'($urandom));
    end
    settle();

    // Drain and give the verdict.
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
